@@ sv/framed_packet_crc_deframer_top_macros.svh @@
// Assertion macros used by the deframer controller RTL.
`ifndef FRAMED_PACKET_CRC_DEFRAMER_TOP_MACROS_SVH
`define FRAMED_PACKET_CRC_DEFRAMER_TOP_MACROS_SVH
`ifndef SYNTH
// Checked only out of reset.
`define FPCD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define FPCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPCD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ sv/fpcd_pkg.sv @@
// Shared types, constants and the CRC-16 step function of the deframer.
package fpcd_pkg;

    localparam logic [7:0]  SYNC_BYTE_1   = 8'h7F;
    localparam logic [7:0]  SYNC_BYTE_2   = 8'hFE;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'h0000;
    localparam int          MAX_PAYLOAD_D = 32;
    localparam int          RESULT_CAP    = 32;
    localparam logic [5:0]  MAX_LEN_RST   = 6'd32;

    typedef enum logic [3:0] {
        S_HUNT,
        S_SYNC2,
        S_TYPE,
        S_LEN,
        S_DATA,
        S_CRC1,
        S_CRC2,
        S_RD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic frame_start;
        logic ld_type;
        logic ld_len;
        logic wr_data;
        logic ld_crc_lo;
        logic k_clr;
        logic k_inc;
        logic rd_en;
    } t_dp_cmd;

    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic len_ok;
        logic len_zero;
        logic fill_done;
        logic crc_match;
        logic frame_empty;
        logic k_last;
    } t_dp_sts;

    // One byte through the reflected CRC-16 (poly 0xA001), LSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ sv/fpcd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module fpcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/fpcd_datapath.sv @@
// Deframer datapath: frame fields, CRC accumulator, payload store and replay index.
module fpcd_datapath
    import fpcd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_D
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_data,
    input  logic [7:0] i_rx_byte,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    output logic [7:0] o_packet_type,
    output logic [5:0] o_payload_len,
    output logic [4:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_last
);

    localparam int         AW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int         CAP = (MAX_PAYLOAD < RESULT_CAP) ? MAX_PAYLOAD : RESULT_CAP;
    localparam logic [5:0] CAP_LEN = 6'(CAP);

    logic [5:0]  r_max_len;
    logic [7:0]  r_frame_type;
    logic [5:0]  r_frame_len;
    logic [5:0]  r_fill;
    logic [7:0]  r_crc_lo;
    logic [15:0] r_crc;
    logic [4:0]  r_k;

    logic [5:0]  limit;
    logic [5:0]  fill_nxt;
    logic [5:0]  k_nxt;
    logic [6:0]  fill_ext;
    logic [6:0]  k_ext;
    logic [15:0] crc_nxt;
    logic [7:0]  rdata;

    assign limit    = (r_max_len > CAP_LEN) ? CAP_LEN : r_max_len;
    assign fill_nxt = r_fill + 6'd1;
    assign k_nxt    = {1'b0, r_k} + 6'd1;
    assign fill_ext = {1'b0, r_fill};
    assign k_ext    = {2'b00, r_k};
    assign crc_nxt  = crc_feed(r_crc, i_rx_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_start) begin
            r_frame_type <= 8'h00;
            r_frame_len  <= 6'd0;
            r_fill       <= 6'd0;
            r_crc        <= CRC_INIT;
        end
        if (i_cmd.ld_type) begin
            r_frame_type <= i_rx_byte;
            r_crc        <= crc_nxt;
        end
        if (i_cmd.ld_len) begin
            r_frame_len <= i_rx_byte[5:0];
            r_fill      <= 6'd0;
            r_crc       <= crc_nxt;
        end
        if (i_cmd.wr_data) begin
            r_fill <= fill_nxt;
            r_crc  <= crc_nxt;
        end
        if (i_cmd.ld_crc_lo) begin
            r_crc_lo <= i_rx_byte;
        end
        if (i_cmd.k_clr) begin
            r_k <= 5'd0;
        end else if (i_cmd.k_inc) begin
            r_k <= k_nxt[4:0];
        end
    end

    fpcd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_data),
        .i_waddr (fill_ext[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd_en),
        .i_raddr (k_ext[AW-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        o_sts.is_sync1    = (i_rx_byte == SYNC_BYTE_1);
        o_sts.is_sync2    = (i_rx_byte == SYNC_BYTE_2);
        o_sts.len_ok      = ({2'b00, limit} >= i_rx_byte);
        o_sts.len_zero    = (i_rx_byte == 8'h00);
        o_sts.fill_done   = (fill_nxt >= r_frame_len);
        o_sts.crc_match   = ({i_rx_byte, r_crc_lo} == r_crc);
        o_sts.frame_empty = (r_frame_len == 6'd0);
        o_sts.k_last      = (k_nxt == r_frame_len) || (r_frame_len == 6'd0);
    end

    assign o_packet_type  = r_frame_type;
    assign o_payload_len  = r_frame_len;
    assign o_byte_index   = r_k;
    assign o_payload_byte = (r_frame_len == 6'd0) ? 8'h00 : rdata;
    assign o_last         = o_sts.k_last;

endmodule

@@ sv/fpcd_ctrl.sv @@
// Deframer controller: parse phases, CRC verdict and payload replay sequencing.
module fpcd_ctrl
    import fpcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_rx_valid,
    output logic    o_rx_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

`include "framed_packet_crc_deframer_top_macros.svh"

    t_state r_state;
    t_state n_state;
    logic   rx_acc;
    logic   out_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_rx_ready  = (r_state != S_RD) && (r_state != S_OUT);
    assign o_out_valid = (r_state == S_OUT);
    assign rx_acc      = i_rx_valid && o_rx_ready;
    assign out_acc     = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_HUNT: begin
                if (rx_acc && i_sts.is_sync1) begin
                    n_state = S_SYNC2;
                end
            end
            S_SYNC2: begin
                if (rx_acc) begin
                    if (i_sts.is_sync2) begin
                        o_cmd.frame_start = 1'b1;
                        n_state = S_TYPE;
                    end else if (!i_sts.is_sync1) begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_TYPE: begin
                if (rx_acc) begin
                    o_cmd.ld_type = 1'b1;
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                if (rx_acc) begin
                    if (!i_sts.len_ok) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.ld_len = 1'b1;
                        n_state = i_sts.len_zero ? S_CRC1 : S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (rx_acc) begin
                    o_cmd.wr_data = 1'b1;
                    if (i_sts.fill_done) begin
                        n_state = S_CRC1;
                    end
                end
            end
            S_CRC1: begin
                if (rx_acc) begin
                    o_cmd.ld_crc_lo = 1'b1;
                    n_state = S_CRC2;
                end
            end
            S_CRC2: begin
                if (rx_acc) begin
                    if (i_sts.crc_match) begin
                        o_cmd.k_clr = 1'b1;
                        n_state = i_sts.frame_empty ? S_OUT : S_RD;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_acc) begin
                    if (i_sts.k_last) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    `FPCD_ASSERT(a_no_rx_during_replay, i_clk, i_rst_n, !(o_rx_ready && o_out_valid), "rx ready while replaying")
    `FPCD_ASSERT(a_bad_crc_drops, i_clk, i_rst_n, (r_state == S_CRC2 && rx_acc && !i_sts.crc_match) |=> (r_state == S_HUNT), "bad CRC did not drop frame")
    `FPCD_ASSERT(a_last_ends_frame, i_clk, i_rst_n, (out_acc && i_sts.k_last) |=> (r_state == S_HUNT), "replay ran past last")
    `FPCD_ASSERT(a_read_before_out, i_clk, i_rst_n, o_cmd.rd_en |=> o_out_valid, "store read not followed by result")
    `FPCD_ASSERT(a_store_write_in_data, i_clk, i_rst_n, o_cmd.wr_data |-> (r_state == S_DATA && rx_acc), "store written outside payload phase")

endmodule

@@ sv/framed_packet_crc_deframer_top.sv @@
// After a frame's last CRC byte is accepted, a store read in S_RD precedes its first result in S_OUT;
// for an empty payload the controller goes straight to S_OUT.
// Throughput: one received byte per cycle while parsing; each replayed result needs a store read in S_RD
// before S_OUT, set by the registered read of the payload store; no byte is taken during replay.
// Reset (synchronous, active low) returns to sync hunt and sets the length limit to 32.
// The payload store is not cleared; only entries of the current frame are ever read.
module framed_packet_crc_deframer_top
    import fpcd_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_D
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_data,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_packet_type,
    output logic [5:0] o_payload_len,
    output logic [4:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    fpcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    fpcd_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_packet_type  (o_packet_type),
        .o_payload_len  (o_payload_len),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last)
    );

endmodule
